>>> rtl/core/awg_pkg.sv
// Shared types, constants and helpers of the waveform table sample generator.
package awg_pkg;

	localparam int IDX_W    = 14;
	localparam int SAMPLE_W = 16;
	localparam int REG_W    = 15;
	localparam int TABLE_N  = 16384;

	// Pipeline depths: the sine datapath sets the depth, the divider is padded up to it.
	localparam int SINE_LAT = 22;
	localparam int DIV_LAT  = 16;
	localparam int Q_PAD    = SINE_LAT - DIV_LAT;

	localparam logic [30:0] ACC_ONE     = 31'h4000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	// Taylor divisors and floor(2^32 / divisor) for the reciprocal multiply.
	localparam logic [7:0]  SIN_DIV   [6] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
	localparam logic [29:0] SIN_RECIP [6] = '{30'd27531841, 30'd39045157, 30'd59652323,
		30'd102261126, 30'd214748364, 30'd715827882};

	typedef enum logic [2:0] {
		WAVE_SINE     = 3'd0,
		WAVE_TRIANGLE = 3'd1,
		WAVE_SQUARE   = 3'd2,
		WAVE_RAMP_UP  = 3'd3,
		WAVE_RAMP_DN  = 3'd4,
		WAVE_DC       = 3'd5,
		WAVE_DC_NEG   = 3'd6,
		WAVE_PWM      = 3'd7
	} wave_t;

	typedef enum logic [1:0] {
		REG_WAVE_SELECT = 2'd0,
		REG_RISE_LENGTH = 2'd1,
		REG_FALL_LENGTH = 2'd2,
		REG_HIGH_COUNT  = 2'd3
	} reg_t;

	typedef enum logic [1:0] {
		SRC_SINE   = 2'd0,
		SRC_DIV    = 2'd1,
		SRC_DIRECT = 2'd2
	} src_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		src_t             src;
		logic             neg;
		logic [17:0]      mag;
	} info_t;

	// Signed saturation of a sign and magnitude: +1.0 maps to the largest positive code.
	function automatic logic signed [SAMPLE_W-1:0] sample_sat(input logic neg,
		input logic [17:0] mag);
		logic signed [SAMPLE_W-1:0] res;
		if (!neg) begin
			res = (mag > 18'd32767) ? 16'sd32767 : SAMPLE_W'(mag);
		end else begin
			res = (mag > 18'd32768) ? -16'sd32768 : SAMPLE_W'(18'd0 - mag);
		end
		return res;
	endfunction

endpackage

>>> rtl/core/awg_stream_if.sv
// Valid/ready stream interfaces for the index input and the sample output.
interface awg_in_if;
	logic                       valid;
	logic                       ready;
	logic [awg_pkg::IDX_W-1:0]  sample_index;

	modport source (output valid, output sample_index, input ready);
	modport sink   (input valid, input sample_index, output ready);
endinterface

interface awg_out_if;
	logic                              valid;
	logic                              ready;
	logic [awg_pkg::IDX_W-1:0]         sample_index_out;
	logic signed [awg_pkg::SAMPLE_W-1:0] sample_value;

	modport source (output valid, output sample_index_out, output sample_value, input ready);
	modport sink   (input valid, input sample_index_out, input sample_value, output ready);
endinterface

>>> rtl/core/awg_sine.sv
// Pipelined Q30 sine: quadrant fold, degree-13 Taylor series, rounding to Q1.15.
module awg_sine (
	input  logic                               clk,
	input  logic                               adv,
	input  logic [awg_pkg::IDX_W-1:0]          x,
	output logic signed [awg_pkg::SAMPLE_W-1:0] value
);
	import awg_pkg::*;

	logic [12:0] rr;
	logic [43:0] prod_t;
	logic [61:0] prod_t2;
	logic [61:0] prod_s;
	logic [32:0] rnd;

	logic [30:0] t_s   [1:20];
	logic        neg_s [1:21];
	logic [31:0] t2_s  [2:17];
	logic [31:0] y_s   [6];
	logic [31:0] yq_s  [6];
	logic [29:0] q0_s  [6];
	logic [30:0] acc_s [6];
	logic [31:0] s_s21;
	logic signed [SAMPLE_W-1:0] value_s22;

	// Odd quadrants run the angle backwards from the quarter point.
	always_comb begin
		rr      = x[12] ? 13'(13'd4096 - 13'(x[11:0])) : 13'(x[11:0]);
		prod_t  = 44'(rr) * 44'(HALF_PI_Q30);
		prod_t2 = 62'(t_s[1]) * 62'(t_s[1]);
		prod_s  = 62'(t_s[20]) * 62'(acc_s[5]);
		rnd     = 33'(s_s21) + 33'd16384;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s[1]    <= prod_t[42:12];
			neg_s[1]  <= x[13];
			t2_s[2]   <= prod_t2[61:30];
			for (int j = 2; j <= 20; j++) t_s[j] <= t_s[j-1];
			for (int j = 2; j <= 21; j++) neg_s[j] <= neg_s[j-1];
			for (int j = 3; j <= 17; j++) t2_s[j] <= t2_s[j-1];
			s_s21     <= prod_s[61:30];
			value_s22 <= sample_sat(neg_s[21], 18'(rnd[32:15]));
		end
	end

	// Horner step k: acc = 1 - (t2 * acc) / div[k], three register stages each.
	for (genvar k = 0; k < 6; k++) begin : g_term
		logic [30:0] acc_in;
		logic [62:0] prod_y;
		logic [61:0] prod_q;
		logic [37:0] qd;
		logic [31:0] rem;
		logic [30:0] q;

		if (k == 0) begin : g_first
			assign acc_in = ACC_ONE;
		end else begin : g_next
			assign acc_in = acc_s[k-1];
		end

		always_comb begin
			prod_y = 63'(t2_s[2+3*k]) * 63'(acc_in);
			prod_q = 62'(y_s[k]) * 62'(SIN_RECIP[k]);
			qd     = 38'(q0_s[k]) * 38'(SIN_DIV[k]);
			rem    = yq_s[k] - qd[31:0];
			// The truncated reciprocal undershoots the quotient by at most one.
			q      = 31'(q0_s[k]) + ((rem >= 32'(SIN_DIV[k])) ? 31'd1 : 31'd0);
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				y_s[k]   <= prod_y[61:30];
				q0_s[k]  <= prod_q[61:32];
				yq_s[k]  <= y_s[k];
				acc_s[k] <= ACC_ONE - q;
			end
		end
	end

	assign value = value_s22;

endmodule

>>> rtl/core/awg_div.sv
// Pipelined restoring divider, one quotient bit per stage, 16-bit quotient.
module awg_div (
	input  logic        clk,
	input  logic        adv,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic [15:0] quotient
);
	import awg_pkg::*;

	logic [31:0] rem_s [0:DIV_LAT-2];
	logic [15:0] dvs_s [0:DIV_LAT-2];
	logic [15:0] q_s   [0:DIV_LAT-1];

	for (genvar i = 0; i < DIV_LAT; i++) begin : g_bit
		logic [31:0] rin;
		logic [15:0] dvs;
		logic [15:0] qin;
		logic [31:0] sh;
		logic        ge;

		if (i == 0) begin : g_head
			assign rin = dividend;
			assign dvs = divisor;
			assign qin = '0;
		end else begin : g_body
			assign rin = rem_s[i-1];
			assign dvs = dvs_s[i-1];
			assign qin = q_s[i-1];
		end

		always_comb begin
			sh = 32'(dvs) << (DIV_LAT - 1 - i);
			ge = (rin >= sh);
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				q_s[i] <= qin | (ge ? (16'd1 << (DIV_LAT - 1 - i)) : 16'd0);
			end
		end

		if (i < DIV_LAT - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[i] <= ge ? (rin - sh) : rin;
					dvs_s[i] <= dvs;
				end
			end
		end
	end

	assign quotient = q_s[DIV_LAT-1];

endmodule

>>> rtl/core/waveform_table_sample_generator_unit.sv
// Top level of the waveform table sample generator: registers, decode, pipeline, output.
//   channel   direction  beat contents
//   in_ch     in         sample_index
//   out_ch    out        sample_index_out, sample_value
//   cfg_*     in         write enable, register index, data (no read-back)
// One beat per cycle enters while in_ch.ready is high; its result passes the input register,
// the pipeline stages and the output register in turn. The depth is set by the sine
// series (six multiply/divide terms, three stages each) that every waveform is aligned to.
// Reset clears the valid bits and returns the registers to their defaults.
// A stall at the output freezes every stage at once, so in_ch.ready follows out_ch.ready
// whenever the output register holds a beat.
module waveform_table_sample_generator_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	awg_in_if.sink                     in_ch,
	awg_out_if.source                  out_ch,
	input  logic                       cfg_wr_en,
	input  awg_pkg::reg_t              cfg_index,
	input  logic [awg_pkg::REG_W-1:0]  cfg_data
);
	import awg_pkg::*;

	wave_t            wave_q;
	logic [REG_W-1:0] rise_q;
	logic [REG_W-1:0] fall_q;
	logic [REG_W-1:0] high_q;

	logic             adv;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s [1:SINE_LAT];
	info_t            info_s [1:SINE_LAT];
	logic [15:0]      qd_s [1:Q_PAD];

	info_t       info_d;
	logic [14:0] div_mag;
	logic [14:0] div_den;
	logic [31:0] dividend;
	logic [15:0] divisor;
	logic [15:0] quotient;
	logic signed [SAMPLE_W-1:0] sine_val;

	logic             out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	logic signed [SAMPLE_W-1:0] out_val_q;
	logic signed [SAMPLE_W-1:0] mux_val;

	// Decode temporaries.
	logic [REG_W-1:0] rlen;
	logic [REG_W-1:0] flen;
	logic [17:0]      x4;
	logic [14:0]      nmf;
	logic [16:0]      npf;
	logic [14:0]      nmr;
	logic signed [16:0] nm2x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= WAVE_SINE;
			rise_q <= REG_W'(1);
			fall_q <= REG_W'(1);
			high_q <= REG_W'(8192);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WAVE_SELECT: wave_q <= wave_t'(cfg_data[2:0]);
				REG_RISE_LENGTH: rise_q <= cfg_data;
				REG_FALL_LENGTH: fall_q <= cfg_data;
				REG_HIGH_COUNT:  high_q <= cfg_data;
			endcase
		end
	end

	assign adv         = !out_valid_q || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int j = 1; j <= SINE_LAT; j++) vld_s[j] <= 1'b0;
		end else if (adv) begin
			vld_s1      <= in_ch.valid;
			vld_s[1]    <= vld_s1;
			for (int j = 2; j <= SINE_LAT; j++) vld_s[j] <= vld_s[j-1];
			out_valid_q <= vld_s[SINE_LAT];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1    <= in_ch.sample_index;
			info_s[1] <= info_d;
			for (int j = 2; j <= SINE_LAT; j++) info_s[j] <= info_s[j-1];
			qd_s[1]   <= quotient;
			for (int j = 2; j <= Q_PAD; j++) qd_s[j] <= qd_s[j-1];
			out_idx_q <= info_s[SINE_LAT].idx;
			out_val_q <= mux_val;
		end
	end

	// Per-waveform decode: a direct value, a division job, or the sine path.
	always_comb begin
		rlen    = (rise_q == '0) ? REG_W'(1) : rise_q;
		flen    = (fall_q == '0) ? REG_W'(1) : fall_q;
		x4      = 18'(idx_s1) << 2;
		nmf     = 15'(TABLE_N) - flen;
		npf     = 17'(TABLE_N) + 17'(flen);
		nmr     = 15'(TABLE_N) - 15'(rlen[14:1]);
		nm2x    = 17'(TABLE_N) - 17'({idx_s1, 1'b0});
		div_mag = '0;
		div_den = 15'd1;
		info_d.idx = idx_s1;
		info_d.src = SRC_DIRECT;
		info_d.neg = 1'b0;
		info_d.mag = '0;
		unique case (wave_q)
			WAVE_SINE: begin
				info_d.src = SRC_SINE;
			end
			WAVE_TRIANGLE: begin
				if (x4 <= 18'd16384) begin
					info_d.mag = x4 << 1;
				end else if (x4 <= 18'd49152) begin
					info_d.neg = (x4 > 18'd32768);
					info_d.mag = (x4 > 18'd32768) ? 18'((x4 - 18'd32768) << 1)
						: 18'((18'd32768 - x4) << 1);
				end else begin
					info_d.neg = 1'b1;
					info_d.mag = 18'((18'd65536 - x4) << 1);
				end
			end
			WAVE_SQUARE: begin
				if (15'(idx_s1) < 15'(rlen[14:1])) begin
					info_d.src = SRC_DIV;
					div_mag    = 15'({idx_s1, 1'b0});
					div_den    = rlen;
				end else if (flen < 15'(TABLE_N) && idx_s1 < nmf[14:1]) begin
					info_d.mag = 18'd32768;
				end else if (16'(idx_s1) < npf[16:1]) begin
					if (flen > 15'd1) begin
						if (nm2x > $signed({2'b00, flen})) begin
							info_d.mag = 18'd32768;
						end else begin
							info_d.src = SRC_DIV;
							info_d.neg = nm2x[16];
							div_mag    = nm2x[16] ? 15'(17'd0 - 17'(nm2x)) : 15'(nm2x);
							div_den    = flen;
						end
					end
				end else if (15'(idx_s1) < nmr) begin
					info_d.neg = 1'b1;
					info_d.mag = 18'd32768;
				end else begin
					info_d.src = SRC_DIV;
					info_d.neg = 1'b1;
					div_mag    = 15'(16'd32768 - 16'({idx_s1, 1'b0}));
					div_den    = rlen;
				end
			end
			WAVE_RAMP_UP: begin
				info_d.mag = (idx_s1 == IDX_W'(TABLE_N - 1)) ? 18'd0
					: 18'((18'(idx_s1) + 18'd2) << 1);
			end
			WAVE_RAMP_DN: begin
				info_d.mag = 18'((18'(TABLE_N) - 18'(idx_s1)) << 1);
			end
			WAVE_DC: begin
				info_d.mag = 18'd32768;
			end
			WAVE_DC_NEG: begin
				info_d.neg = 1'b1;
				info_d.mag = 18'd32768;
			end
			WAVE_PWM: begin
				info_d.neg = !(15'(idx_s1) < high_q);
				info_d.mag = 18'd32768;
			end
		endcase
		// Rounded quotient: (mag * 2^16 + den) / (2 * den).
		dividend = {1'b0, div_mag, 16'd0} + 32'(div_den);
		divisor  = {div_den, 1'b0};
	end

	always_comb begin
		unique case (info_s[SINE_LAT].src)
			SRC_SINE: mux_val = sine_val;
			SRC_DIV:  mux_val = sample_sat(info_s[SINE_LAT].neg, 18'(qd_s[Q_PAD]));
			default:  mux_val = sample_sat(info_s[SINE_LAT].neg, info_s[SINE_LAT].mag);
		endcase
	end

	awg_sine u_sine (
		.clk   (clk),
		.adv   (adv),
		.x     (idx_s1),
		.value (sine_val)
	);

	awg_div u_div (
		.clk      (clk),
		.adv      (adv),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quotient)
	);

	assign out_ch.valid            = out_valid_q;
	assign out_ch.sample_index_out = out_idx_q;
	assign out_ch.sample_value     = out_val_q;

endmodule

>>> rtl/core/awg_chk.sv
// Port-level assertions for the waveform table sample generator, bound to the top level.
module awg_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [awg_pkg::IDX_W-1:0]         out_idx,
	input logic signed [awg_pkg::SAMPLE_W-1:0] out_val
);
	import awg_pkg::*;

	// A held result stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_idx) && $stable(out_val))
		else $error("output beat changed while stalled");

	// The whole pipeline stalls with the output, so no beat may enter then.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");

	// With the output free the block always takes a beat.
	a_free_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output register");

	// Reset holds the output empty.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind waveform_table_sample_generator_unit awg_chk u_awg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_idx   (out_ch.sample_index_out),
	.out_val   (out_ch.sample_value)
);
